[hw/rtl/gcu_pkg.sv]
// gcu_pkg: shared types, constants and the microcode ROM for the GCD/LCM unit.
// Used by gcd_lcm_unit_top; no dependencies.
package gcu_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned FieldWidth      = 16;
  localparam int unsigned ResultWidth     = 32;
  localparam int unsigned UpcWidth        = 4;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD     = 4'd1,  // take a request into A, B, X, Y
    OP_DIV_AB   = 4'd2,  // start divider: A / B
    OP_SWAP     = 4'd3,  // A <= B, B <= A mod B
    OP_DIV_XA   = 4'd4,  // start divider: X / gcd
    OP_MUL      = 4'd5,  // result <= quotient * Y
    OP_RES_GCD  = 4'd6,  // result <= A
    OP_RES_ZERO = 4'd7,  // result <= 0, not found
    OP_PUSH     = 4'd8   // move result into the output register
  } op_e;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_INPUT  = 3'd2,
    C_ZERO_CASE = 3'd3,
    C_B_ZERO    = 3'd4,
    C_FUNC_GCD  = 3'd5,
    C_DIV_BUSY  = 3'd6,
    C_OUT_FULL  = 3'd7
  } cond_e;

  typedef logic [UpcWidth-1:0] upc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ctrl_word_t;

  // Program step addresses
  localparam upc_t S_FETCH    = 4'd0;
  localparam upc_t S_CHECK    = 4'd1;
  localparam upc_t S_LOOP     = 4'd2;
  localparam upc_t S_DIV1     = 4'd3;
  localparam upc_t S_WAIT1    = 4'd4;
  localparam upc_t S_SWAP     = 4'd5;
  localparam upc_t S_GCD_DONE = 4'd6;
  localparam upc_t S_DIV2     = 4'd7;
  localparam upc_t S_WAIT2    = 4'd8;
  localparam upc_t S_MUL      = 4'd9;
  localparam upc_t S_RES_GCD  = 4'd10;
  localparam upc_t S_FAIL     = 4'd11;
  localparam upc_t S_EMIT     = 4'd12;
  localparam upc_t S_RETURN   = 4'd13;

  function automatic ctrl_word_t ucode(input upc_t step);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
    case (step)
      S_FETCH:    cw = '{op: OP_LOAD,     cond: C_NO_INPUT,  target: S_FETCH};
      S_CHECK:    cw = '{op: OP_NOP,      cond: C_ZERO_CASE, target: S_FAIL};
      S_LOOP:     cw = '{op: OP_NOP,      cond: C_B_ZERO,    target: S_GCD_DONE};
      S_DIV1:     cw = '{op: OP_DIV_AB,   cond: C_NEVER,     target: S_FETCH};
      S_WAIT1:    cw = '{op: OP_NOP,      cond: C_DIV_BUSY,  target: S_WAIT1};
      S_SWAP:     cw = '{op: OP_SWAP,     cond: C_ALWAYS,    target: S_LOOP};
      S_GCD_DONE: cw = '{op: OP_NOP,      cond: C_FUNC_GCD,  target: S_RES_GCD};
      S_DIV2:     cw = '{op: OP_DIV_XA,   cond: C_NEVER,     target: S_FETCH};
      S_WAIT2:    cw = '{op: OP_NOP,      cond: C_DIV_BUSY,  target: S_WAIT2};
      S_MUL:      cw = '{op: OP_MUL,      cond: C_ALWAYS,    target: S_EMIT};
      S_RES_GCD:  cw = '{op: OP_RES_GCD,  cond: C_ALWAYS,    target: S_EMIT};
      S_FAIL:     cw = '{op: OP_RES_ZERO, cond: C_NEVER,     target: S_FETCH};
      S_EMIT:     cw = '{op: OP_PUSH,     cond: C_OUT_FULL,  target: S_EMIT};
      S_RETURN:   cw = '{op: OP_NOP,      cond: C_ALWAYS,    target: S_FETCH};
      default:    cw = '{op: OP_NOP,      cond: C_ALWAYS,    target: S_FETCH};
    endcase
    return cw;
  endfunction

endpackage

[hw/rtl/gcu_div.sv]
// gcu_div: restoring divider, one quotient bit per cycle.
// Standalone; instantiated by gcd_lcm_unit_top.
module gcu_div #(
  parameter int unsigned Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [Width-1:0]    quo_q, quo_d;
  logic [Width-1:0]    rem_q, rem_d;
  logic [Width-1:0]    dvs_q, dvs_d;
  logic [Width:0]      trial;
  logic [Width:0]      diff;

  assign trial = {rem_q, quo_q[Width-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntWidth'(Width);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[Width]) begin
        rem_d = diff[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[hw/rtl/gcd_lcm_unit_top.sv]
// gcd_lcm_unit_top: GCD / LCM of two unsigned operands, microcoded sequencer.
// Depends on gcu_pkg (types, microcode ROM) and gcu_div (iterative divider).
//
// Usage:
//   Request channel (in_valid_i / in_ready_o) carries func_i (0 = LCM, 1 = GCD)
//   and two 16-bit operands; only their low OPERAND_WIDTH bits are used.
//   Response channel (out_valid_o / out_ready_i) carries result_value_o and
//   found_o. Exactly one response per request, in order.
//   One request is worked on at a time; in_ready_o is high only while the
//   sequencer sits at its fetch step. The response sits in an output
//   register, so the sequencer returns to fetch while the receiver stalls,
//   unless an older response is still held there.
//   Each request is loaded and checked, then each Euclid step runs a divide
//   on the shared divider (one quotient bit per cycle) and a swap; the LCM
//   then divides X by the gcd and multiplies, while GCD takes A as result;
//   the response is then handed off and the sequencer returns to fetch.
//   Zero-operand cases (A zero, or B zero for LCM) go straight to a zero,
//   not-found result. The divider bounds the rate.
//   Reset (rst_ni low, async) returns the sequencer to fetch and drops any
//   pending response; the operand registers need no reset.
module gcd_lcm_unit_top
  import gcu_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [FieldWidth-1:0]  first_value_i,
  input  logic [FieldWidth-1:0]  second_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ResultWidth-1:0] result_value_o,
  output logic                   found_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  // Microcode sequencer
  upc_t       upc_q, upc_d;
  ctrl_word_t cw;
  logic       jump;

  // Datapath registers: A/B run Euclid, X/Y keep the original operands
  logic [W-1:0]             a_q, a_d, b_q, b_d, x_q, x_d, y_q, y_d;
  logic                     func_q, func_d;
  logic [ResultWidth-1:0]   res_q, res_d;
  logic                     found_q, found_d;
  logic [ResultWidth-1:0]   out_value_q, out_value_d;
  logic                     out_found_q, out_found_d;
  logic                     out_valid_q, out_valid_d;

  logic [ResultWidth-1:0]   first_ext, second_ext;
  logic [W-1:0]             first_op, second_op;
  logic                     out_full;

  // Divider
  logic                     div_start;
  logic [W-1:0]             div_dividend, div_divisor;
  logic                     div_busy;
  logic [W-1:0]             div_quo, div_rem;

  logic [2*W-1:0]           prod;
  logic [63:0]              prod_ext;

  assign first_ext  = ResultWidth'(first_value_i);
  assign second_ext = ResultWidth'(second_value_i);
  assign first_op   = first_ext[W-1:0];
  assign second_op  = second_ext[W-1:0];

  assign cw         = ucode(upc_q);
  assign in_ready_o = (cw.op == OP_LOAD);
  assign out_full   = out_valid_q && !out_ready_i;

  // Jump condition
  always_comb begin
    case (cw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !in_valid_i;
      C_ZERO_CASE: jump = (a_q == '0) || (!func_q && (b_q == '0));
      C_B_ZERO:    jump = (b_q == '0);
      C_FUNC_GCD:  jump = func_q;
      C_DIV_BUSY:  jump = div_busy;
      C_OUT_FULL:  jump = out_full;
      default:     jump = 1'b1;
    endcase
  end

  assign upc_d = jump ? cw.target : upc_q + 1'b1;

  // Divider operand select
  assign div_start    = (cw.op == OP_DIV_AB) || (cw.op == OP_DIV_XA);
  assign div_dividend = (cw.op == OP_DIV_XA) ? x_q : a_q;
  assign div_divisor  = (cw.op == OP_DIV_XA) ? a_q : b_q;

  // LCM = (X / gcd) * Y, low 32 bits kept
  assign prod     = (2*W)'(div_quo) * (2*W)'(y_q);
  assign prod_ext = 64'(prod);

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    y_d         = y_q;
    func_d      = func_q;
    res_d       = res_q;
    found_d     = found_q;
    out_value_d = out_value_q;
    out_found_d = out_found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cw.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          a_d    = first_op;
          b_d    = second_op;
          x_d    = first_op;
          y_d    = second_op;
          func_d = func_i;
        end
      end
      OP_SWAP: begin
        a_d = b_q;
        b_d = div_rem;
      end
      OP_MUL: begin
        res_d   = prod_ext[ResultWidth-1:0];
        found_d = 1'b1;
      end
      OP_RES_GCD: begin
        res_d   = ResultWidth'(a_q);
        found_d = 1'b1;
      end
      OP_RES_ZERO: begin
        res_d   = '0;
        found_d = 1'b0;
      end
      OP_PUSH: begin
        if (!out_full) begin
          out_value_d = res_q;
          out_found_d = found_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    x_q         <= x_d;
    y_q         <= y_d;
    func_q      <= func_d;
    res_q       <= res_d;
    found_q     <= found_d;
    out_value_q <= out_value_d;
    out_found_q <= out_found_d;
  end

  gcu_div #(
    .Width (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign found_o        = out_found_q;

  // Checks
  a_no_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> result_value_o == '0)
    else $error("response without result must carry zero");

  a_fetch_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while taking a request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken before the first completed");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= S_RETURN)
    else $error("sequencer left the program");

endmodule
